[src/dpr_pkg.sv]
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types and constants for the bitmap pixel to RGBA converter.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    typedef enum logic [2:0] {
        FMT_1BPP  = 3'd0,
        FMT_4BPP  = 3'd1,
        FMT_8BPP  = 3'd2,
        FMT_24BPP = 3'd3,
        FMT_32BPP = 3'd4
    } fmt_t;

    typedef enum logic [2:0] {
        REG_FORMAT    = 3'd0,
        REG_BITFIELDS = 3'd1,
        REG_RED_MASK  = 3'd2,
        REG_GRN_MASK  = 3'd3,
        REG_BLU_MASK  = 3'd4,
        REG_ALP_MASK  = 3'd5,
        REG_WIDTH     = 3'd6,
        REG_PAL_COUNT = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SCALE
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] index;
        logic       row_end;
        logic       last;
        logic       bad;
    } pal_req_t;

endpackage

[src/dib_pixel_to_rgba_converter.sv]
// ----------------------------------------------------------------------------
// dib_pixel_to_rgba_converter
// Unpacks bitmap pixel words into RGBA8 pixels, palette and bitfield modes.
//
//   channel  dir  handshake            payload
//   s_axis   in   tvalid/tready        tdata {color,index,word}, tuser req_type
//   m_axis   out  tvalid/tready/tlast  tdata {a,b,g,r}, tuser {bad,row_end}
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// A data word is accepted, its source slots are scanned in order (32 bits at
// 1 bpp, 8 nibbles at 4 bpp, 4 bytes at 8 and 24 bpp, one word at 32 bpp,
// cut short at the row end), and the row position is then updated. Each
// palette pixel holds the scan until its memory read returns. Bitfield words
// run one division per channel with a nonzero mask on one shared serial
// divider. Reset clears position state; the palette is undefined until
// written. Output stalls hold the emitter in place.
// ----------------------------------------------------------------------------
module dib_pixel_to_rgba_converter #(
    parameter int MAX_WIDTH     = dpr_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = dpr_pkg::PALETTE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_word, palette_index, palette_color
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // row_end, bad_index
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int BW = $clog2(MAX_WIDTH * 4 + 5);

    logic [2:0]  fmt_reg;
    logic        bitf_reg;
    logic [31:0] mask_reg [4];
    logic [12:0] width_reg;
    logic [8:0]  pcnt_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [BW-1:0] rbp_reg, rbp_next;
    logic [15:0]   carry_reg, carry_next;
    logic [1:0]    ccnt_reg, ccnt_next;

    dpr_pkg::state_t state_reg, state_next;
    logic [31:0] word_reg, word_next;
    logic [5:0]  sub_reg, sub_next;
    logic [5:0]  nsub_reg, nsub_next;
    logic [1:0]  ch_reg, ch_next;
    logic [7:0]  chan_reg [4];

    logic [CW-1:0] width_eff;
    logic [2:0]    fmt;
    logic [BW-1:0] stride;

    logic        ob_valid_reg;
    logic [31:0] ob_data_reg;
    logic        ob_last_reg, ob_re_reg, ob_bad_reg;

    dpr_pkg::pal_req_t pal_req, pal_rsp;
    logic [23:0]       pal_color;
    logic              pal_pend_reg;

    logic        div_start, div_done;
    logic [31:0] div_q, div_a, div_b;
    logic        div_wait_reg, div_wait_next;

    logic        acc, is_pix, can_out;
    logic        emit_direct;
    logic [31:0] direct_data;
    logic        direct_last, direct_re;

    logic [4:0]  shift_amt;
    logic [31:0] mask_cur, field, maxv;
    logic [31:0] field_mul;

    always_comb
    begin
        width_eff = (width_reg == 13'd0) ? CW'(1) :
                    ({19'd0, width_reg} > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_reg);
        fmt = (fmt_reg > dpr_pkg::FMT_32BPP) ? dpr_pkg::FMT_32BPP : fmt_reg;
        case (dpr_pkg::fmt_t'(fmt))
            dpr_pkg::FMT_1BPP:  stride = BW'(((32'(width_eff) + 32'd31) >> 5) << 2);
            dpr_pkg::FMT_4BPP:  stride = BW'(((32'(width_eff) * 4 + 32'd31) >> 5) << 2);
            dpr_pkg::FMT_8BPP:  stride = BW'(((32'(width_eff) * 8 + 32'd31) >> 5) << 2);
            dpr_pkg::FMT_24BPP: stride = BW'(((32'(width_eff) * 24 + 32'd31) >> 5) << 2);
            default:            stride = BW'(32'(width_eff) * 4);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= dpr_pkg::FMT_32BPP;
            bitf_reg    <= 1'b0;
            mask_reg[0] <= 32'h00FF0000;
            mask_reg[1] <= 32'h0000FF00;
            mask_reg[2] <= 32'h000000FF;
            mask_reg[3] <= 32'h0;
            width_reg   <= 13'd1;
            pcnt_reg    <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (dpr_pkg::reg_idx_t'(cfg_index))
                dpr_pkg::REG_FORMAT:    fmt_reg     <= cfg_data[2:0];
                dpr_pkg::REG_BITFIELDS: bitf_reg    <= cfg_data[0];
                dpr_pkg::REG_RED_MASK:  mask_reg[0] <= cfg_data;
                dpr_pkg::REG_GRN_MASK:  mask_reg[1] <= cfg_data;
                dpr_pkg::REG_BLU_MASK:  mask_reg[2] <= cfg_data;
                dpr_pkg::REG_ALP_MASK:  mask_reg[3] <= cfg_data;
                dpr_pkg::REG_WIDTH:     width_reg   <= cfg_data[12:0];
                dpr_pkg::REG_PAL_COUNT: pcnt_reg    <= cfg_data[8:0];
                default:                fmt_reg     <= fmt_reg;
            endcase
        end
    end

    // output slot is free for a new pixel
    assign can_out = !ob_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == dpr_pkg::ST_IDLE);
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign is_pix = !s_axis_tuser;

    // bit field extraction for current channel
    always_comb
    begin
        mask_cur  = mask_reg[ch_reg];
        shift_amt = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (mask_cur[i])
            begin
                shift_amt = 5'(i);
            end
        end
        field     = (word_reg & mask_cur) >> shift_amt;
        maxv      = mask_cur >> shift_amt;
        field_mul = (field << 8) - field;
        div_a     = field_mul + (maxv >> 1);
        div_b     = maxv;
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        rbp_next      = rbp_reg;
        carry_next    = carry_reg;
        ccnt_next     = ccnt_reg;
        word_next     = word_reg;
        sub_next      = sub_reg;
        nsub_next     = nsub_reg;
        ch_next       = ch_reg;
        div_wait_next = div_wait_reg;
        div_start     = 1'b0;
        pal_req       = '0;
        emit_direct   = 1'b0;
        direct_data   = '0;
        direct_last   = 1'b0;
        direct_re     = 1'b0;
        case (state_reg)
            dpr_pkg::ST_IDLE:
            begin
                if (acc && is_pix)
                begin
                    word_next = s_axis_tdata[31:0];
                    sub_next  = 6'd0;
                    ch_next   = 2'd0;
                    case (dpr_pkg::fmt_t'(fmt))
                        dpr_pkg::FMT_1BPP:  nsub_next = 6'd32;
                        dpr_pkg::FMT_4BPP:  nsub_next = 6'd8;
                        dpr_pkg::FMT_24BPP: nsub_next = 6'd4;
                        dpr_pkg::FMT_8BPP:  nsub_next = 6'd4;
                        default:            nsub_next = 6'd1;
                    endcase
                    if (fmt == dpr_pkg::FMT_32BPP && bitf_reg)
                    begin
                        state_next = dpr_pkg::ST_SCALE;
                    end
                    else
                    begin
                        state_next = dpr_pkg::ST_EMIT;
                    end
                end
            end
            dpr_pkg::ST_EMIT:
            begin
                if (can_out && !pal_pend_reg)
                begin
                    logic       stop, emits, lastp, rend;
                    logic [7:0] idx;
                    logic [7:0] byte_v;
                    stop   = (col_reg >= width_eff) || (sub_reg >= nsub_reg);
                    byte_v = word_reg[8*sub_reg[1:0] +: 8];
                    idx    = 8'd0;
                    emits  = 1'b0;
                    lastp  = 1'b0;
                    rend   = (col_reg + CW'(1)) == width_eff;
                    case (dpr_pkg::fmt_t'(fmt))
                        dpr_pkg::FMT_1BPP:
                        begin
                            idx   = {7'd0, word_reg[{sub_reg[4:3], 3'd7 - sub_reg[2:0]}]};
                            emits = 1'b1;
                            lastp = rend || sub_reg == 6'd31;
                        end
                        dpr_pkg::FMT_4BPP:
                        begin
                            idx   = sub_reg[0] ? {4'd0, word_reg[8*sub_reg[2:1] +: 4]}
                                               : {4'd0, word_reg[8*sub_reg[2:1] + 4 +: 4]};
                            emits = 1'b1;
                            lastp = rend || sub_reg == 6'd7;
                        end
                        dpr_pkg::FMT_8BPP:
                        begin
                            idx   = byte_v;
                            emits = 1'b1;
                            lastp = rend || sub_reg == 6'd3;
                        end
                        dpr_pkg::FMT_24BPP:
                        begin
                            emits = (ccnt_reg == 2'd2);
                            // last pixel of word only if no later 3rd byte here
                            lastp = rend || (sub_reg == 6'd3) ||
                                    (sub_reg == 6'd2 ? 1'b1 : 1'b0) ||
                                    (sub_reg <= 6'd1 ? 1'b0 : 1'b0);
                        end
                        default:
                        begin
                            emits = 1'b1;
                            lastp = 1'b1;
                        end
                    endcase
                    if (!stop)
                    begin
                        sub_next = sub_reg + 6'd1;
                        if (fmt == dpr_pkg::FMT_24BPP)
                        begin
                            if (ccnt_reg < 2'd2)
                            begin
                                carry_next = carry_reg | (16'(byte_v) << (8 * ccnt_reg));
                                ccnt_next  = ccnt_reg + 2'd1;
                            end
                            else
                            begin
                                col_next    = col_reg + CW'(1);
                                emit_direct = 1'b1;
                                direct_data = {8'hFF, carry_reg[7:0], carry_reg[15:8],
                                               byte_v};
                                direct_re   = rend;
                                direct_last = rend || sub_reg >= 6'd1;
                                carry_next  = '0;
                                ccnt_next   = '0;
                            end
                        end
                        else if (fmt == dpr_pkg::FMT_32BPP)
                        begin
                            col_next    = col_reg + CW'(1);
                            emit_direct = 1'b1;
                            direct_data = (bitf_reg) ?
                                {chan_reg[3], chan_reg[2], chan_reg[1], chan_reg[0]} :
                                {(word_reg[31:24] == 8'd0) ? 8'hFF : word_reg[31:24],
                                 word_reg[7:0], word_reg[15:8], word_reg[23:16]};
                            direct_re   = rend;
                            direct_last = 1'b1;
                        end
                        else if (emits)
                        begin
                            col_next      = col_reg + CW'(1);
                            pal_req.valid = 1'b1;
                            pal_req.index = idx;
                            pal_req.row_end = rend;
                            pal_req.last  = lastp;
                            pal_req.bad   = ({1'b0, idx} >= pcnt_reg) ||
                                            ({24'd0, idx} >= PALETTE_DEPTH);
                        end
                    end
                    else
                    begin
                        state_next = dpr_pkg::ST_IDLE;
                        if (32'(rbp_reg) + 32'd4 >= 32'(stride))
                        begin
                            rbp_next   = '0;
                            col_next   = '0;
                            carry_next = '0;
                            ccnt_next  = '0;
                        end
                        else
                        begin
                            rbp_next = rbp_reg + BW'(4);
                        end
                    end
                end
            end
            dpr_pkg::ST_SCALE:
            begin
                if (!div_wait_reg)
                begin
                    if (mask_cur == 32'd0)
                    begin
                        ch_next = ch_reg + 2'd1;
                        if (ch_reg == 2'd3)
                        begin
                            state_next = dpr_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        div_start     = 1'b1;
                        div_wait_next = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    div_wait_next = 1'b0;
                    ch_next       = ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        state_next = dpr_pkg::ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = dpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dpr_pkg::ST_SCALE)
        begin
            if (!div_wait_reg && mask_cur == 32'd0)
            begin
                chan_reg[ch_reg] <= 8'hFF;
            end
            else if (div_wait_reg && div_done)
            begin
                chan_reg[ch_reg] <= div_q[7:0];
            end
        end
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dpr_pkg::ST_IDLE;
            col_reg      <= '0;
            rbp_reg      <= '0;
            carry_reg    <= '0;
            ccnt_reg     <= '0;
            sub_reg      <= '0;
            nsub_reg     <= '0;
            ch_reg       <= '0;
            div_wait_reg <= 1'b0;
            pal_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            rbp_reg      <= rbp_next;
            carry_reg    <= carry_next;
            ccnt_reg     <= ccnt_next;
            sub_reg      <= sub_next;
            nsub_reg     <= nsub_next;
            ch_reg       <= ch_next;
            div_wait_reg <= div_wait_next;
            pal_pend_reg <= pal_req.valid;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
        end
        else if (pal_rsp.valid || emit_direct)
        begin
            ob_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ob_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_rsp.valid)
        begin
            ob_data_reg <= {8'hFF, pal_color[7:0], pal_color[15:8], pal_color[23:16]};
            ob_last_reg <= pal_rsp.last;
            ob_re_reg   <= pal_rsp.row_end;
            ob_bad_reg  <= pal_rsp.bad;
        end
        else if (emit_direct)
        begin
            ob_data_reg <= direct_data;
            ob_last_reg <= direct_last;
            ob_re_reg   <= direct_re;
            ob_bad_reg  <= 1'b0;
        end
    end

    dpr_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (acc && !is_pix),
        .wr_index (s_axis_tdata[39:32]),
        .wr_color (s_axis_tdata[63:40]),
        .rd_req   (pal_req),
        .rd_rsp   (pal_rsp),
        .rd_color (pal_color)
    );

    dpr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_axis_tvalid = ob_valid_reg;
    assign m_axis_tdata  = ob_data_reg;
    assign m_axis_tlast  = ob_last_reg;
    assign m_axis_tuser  = {ob_bad_reg, ob_re_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dpr_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_pal_resp: assert property (@(posedge clk) disable iff (!rst_n)
        pal_req.valid |=> pal_rsp.valid)
        else $error("palette read lost");
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_WIDTH))
        else $error("column past max width");

endmodule

[src/dpr_divider.sv]
// ----------------------------------------------------------------------------
// dpr_divider
// Radix-2 restoring divider, 32-bit unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module dpr_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/dpr_palette.sv]
// ----------------------------------------------------------------------------
// dpr_palette
// Palette memory with registered read; carries pixel flags alongside.
// ----------------------------------------------------------------------------
module dpr_palette #(
    parameter int PALETTE_DEPTH = dpr_pkg::PALETTE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [7:0]        wr_index,
    input  logic [23:0]       wr_color,
    input  dpr_pkg::pal_req_t rd_req,
    output dpr_pkg::pal_req_t rd_rsp,
    output logic [23:0]       rd_color
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [23:0]       mem [PALETTE_DEPTH];
    logic [23:0]       color_reg;
    dpr_pkg::pal_req_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && ({24'd0, wr_index} < PALETTE_DEPTH))
        begin
            mem[wr_index[AW-1:0]] <= wr_color;
        end
        if (rd_req.valid)
        begin
            color_reg <= mem[rd_req.index[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg <= rd_req;
        end
    end

    assign rd_rsp   = rsp_reg;
    assign rd_color = rsp_reg.bad ? 24'd0 : color_reg;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap pixel to RGBA converter. Loads the
// palette, walks through a series of format, mask, width and palette-count
// settings, and drives data and palette beats with random gaps while the
// pixel side stalls at random. A scoreboard predicts every output pixel and
// compares it field by field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       row_end;
    logic       bad;
    logic       last;
} rgba_px_t;

class rgba_scoreboard;
    bit [2:0]  pix_fmt;
    bit        bitfields;
    bit [31:0] r_mask, g_mask, b_mask, a_mask;
    bit [12:0] width_reg;
    bit [8:0]  pal_count;
    bit [31:0] col, row_bytes, carry, carry_n;
    bit [23:0] palette [256];
    rgba_px_t  px_q [$];
    int        errors;

    function new();
        pix_fmt = dpr_pkg::FMT_32BPP;
        bitfields = 0;
        r_mask = 32'h00FF0000;
        g_mask = 32'h0000FF00;
        b_mask = 32'h000000FF;
        a_mask = 0;
        width_reg = 1;
        pal_count = 256;
        col = 0;
        row_bytes = 0;
        carry = 0;
        carry_n = 0;
        errors = 0;
    endfunction

    function void write_reg(dpr_pkg::reg_idx_t idx, bit [31:0] v);
        case (idx)
            dpr_pkg::REG_FORMAT:    pix_fmt = v[2:0];
            dpr_pkg::REG_BITFIELDS: bitfields = v[0];
            dpr_pkg::REG_RED_MASK:  r_mask = v;
            dpr_pkg::REG_GRN_MASK:  g_mask = v;
            dpr_pkg::REG_BLU_MASK:  b_mask = v;
            dpr_pkg::REG_ALP_MASK:  a_mask = v;
            dpr_pkg::REG_WIDTH:     width_reg = v[12:0];
            dpr_pkg::REG_PAL_COUNT: pal_count = v[8:0];
            default:                pal_count = pal_count;
        endcase
    endfunction

    function bit [7:0] scale(bit [31:0] v, bit [31:0] m);
        int unsigned sh;
        bit [31:0] f, mx, p, q;
        if (m == 0)
            return 8'd255;
        sh = 0;
        while (!m[sh])
            sh++;
        f = (v & m) >> sh;
        mx = m >> sh;
        p = f * 32'd255 + mx / 2;
        q = p / mx;
        return q[7:0];
    endfunction

    function void push_px(bit [7:0] r, g, b, a, bit bad, bit [31:0] w);
        rgba_px_t p;
        col++;
        p.r = r;
        p.g = g;
        p.b = b;
        p.a = a;
        p.row_end = (col == w);
        p.bad = bad;
        p.last = 0;
        px_q.push_back(p);
    endfunction

    function void push_index(bit [7:0] idx, bit [31:0] w);
        bit [23:0] c;
        if (idx >= pal_count)
            push_px(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, w);
        else
        begin
            c = palette[idx];
            push_px(c[23:16], c[15:8], c[7:0], 8'd255, 1'b0, w);
        end
    endfunction

    function void note_beat(bit req, bit [31:0] word, bit [7:0] pidx, bit [23:0] pcol);
        bit [31:0] w, bpp, stride;
        bit [2:0]  f;
        bit [7:0]  byt;
        int        start, k;
        if (req)
        begin
            palette[pidx] = pcol;
            return;
        end
        start = px_q.size();
        w = (width_reg == 0) ? 1 : (width_reg > 4096) ? 4096 : width_reg;
        f = (pix_fmt > dpr_pkg::FMT_32BPP) ? dpr_pkg::FMT_32BPP : pix_fmt;
        case (f)
            dpr_pkg::FMT_1BPP:  bpp = 1;
            dpr_pkg::FMT_4BPP:  bpp = 4;
            dpr_pkg::FMT_8BPP:  bpp = 8;
            dpr_pkg::FMT_24BPP: bpp = 24;
            default:            bpp = 32;
        endcase
        stride = ((w * bpp + 31) / 32) * 4;
        if (f == dpr_pkg::FMT_32BPP)
        begin
            if (col < w)
            begin
                if (bitfields)
                    push_px(scale(word, r_mask), scale(word, g_mask), scale(word, b_mask),
                            (a_mask != 0) ? scale(word, a_mask) : 8'd255, 1'b0, w);
                else
                    push_px(word[23:16], word[15:8], word[7:0],
                            (word[31:24] == 0) ? 8'd255 : word[31:24], 1'b0, w);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                byt = word[8*i +: 8];
                if (col >= w)
                    break;
                if (f == dpr_pkg::FMT_1BPP)
                begin
                    for (k = 0; k < 8 && col < w; k++)
                        push_index({7'd0, byt[7-k]}, w);
                end
                else if (f == dpr_pkg::FMT_4BPP)
                begin
                    push_index({4'd0, byt[7:4]}, w);
                    if (col < w)
                        push_index({4'd0, byt[3:0]}, w);
                end
                else if (f == dpr_pkg::FMT_8BPP)
                    push_index(byt, w);
                else if (carry_n < 2)
                begin
                    carry |= byt << (8 * carry_n);
                    carry_n++;
                end
                else
                begin
                    push_px(byt, carry[15:8], carry[7:0], 8'd255, 1'b0, w);
                    carry = 0;
                    carry_n = 0;
                end
            end
        end
        row_bytes += 4;
        if (row_bytes >= stride)
        begin
            row_bytes = 0;
            col = 0;
            carry = 0;
            carry_n = 0;
        end
        if (px_q.size() > start)
            px_q[px_q.size()-1].last = 1;
    endfunction

    function void check_px(rgba_px_t got);
        rgba_px_t want;
        if (px_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel %h", got);
            return;
        end
        want = px_q.pop_front();
        if (got != want)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("pixel mismatch: expected r%h g%h b%h a%h re%b bad%b l%b",
                         want.r, want.g, want.b, want.a, want.row_end, want.bad, want.last);
                $display("                got      r%h g%h b%h a%h re%b bad%b l%b",
                         got.r, got.g, got.b, got.a, got.row_end, got.bad, got.last);
            end
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // data_word, palette_index, palette_color
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // red, green, blue, alpha
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;   // row_end, bad_index
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    rgba_scoreboard sb;
    bit  quiet;
    int  cycles;
    int  stall_left;

    dib_pixel_to_rgba_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1000000)
            begin
                $display("FAIL dib_pixel_to_rgba_converter");
                $finish;
            end
        end
    end

    // pixel side: random stall bursts, check every accepted beat
    initial
    begin
        rgba_px_t p;
        m_axis_tready = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                p.r = m_axis_tdata[7:0];
                p.g = m_axis_tdata[15:8];
                p.b = m_axis_tdata[23:16];
                p.a = m_axis_tdata[31:24];
                p.row_end = m_axis_tuser[0];
                p.bad = m_axis_tuser[1];
                p.last = m_axis_tlast;
                sb.check_px(p);
            end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic send_beat(bit req, bit [31:0] word, bit [7:0] pidx, bit [23:0] pcol);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= req;
        s_axis_tdata <= {pcol, pidx, word};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_beat(req, word, pidx, pcol);
    endtask

    task automatic cfg_write(dpr_pkg::reg_idx_t idx, bit [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.px_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic configure(bit [2:0] f, bit bf, bit [31:0] rm, gm, bm, am,
                             bit [12:0] w, bit [8:0] pc);
        drain();
        cfg_write(dpr_pkg::REG_FORMAT, 32'(f));
        cfg_write(dpr_pkg::REG_BITFIELDS, 32'(bf));
        cfg_write(dpr_pkg::REG_RED_MASK, rm);
        cfg_write(dpr_pkg::REG_GRN_MASK, gm);
        cfg_write(dpr_pkg::REG_BLU_MASK, bm);
        cfg_write(dpr_pkg::REG_ALP_MASK, am);
        cfg_write(dpr_pkg::REG_WIDTH, 32'(w));
        cfg_write(dpr_pkg::REG_PAL_COUNT, 32'(pc));
        cfg_we <= 0;
    endtask

    function automatic bit [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_words(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_beat(1'b1, $urandom(), 8'($urandom_range(0, 255)), 24'($urandom()));
            else
                send_beat(1'b0, pick_word(), 8'($urandom()), 24'($urandom()));
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        cfg_we = 0;
        cfg_index = dpr_pkg::REG_FORMAT;
        cfg_data = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // load entries 0..15; palette counts below keep every read inside them
        for (int i = 0; i < 16; i++)
            send_beat(1'b1, $urandom(), 8'(i),
                      (i == 0) ? 24'h0 : (i == 15) ? 24'hFFFFFF : 24'($urandom()));

        // reset settings: plain 32 bpp, alpha zero and extremes
        send_beat(1'b0, 32'h00FFFFFF, 8'd0, 24'd0);
        send_beat(1'b0, 32'hFFFFFFFF, 8'd0, 24'd0);
        send_beat(1'b0, 32'h00000000, 8'd0, 24'd0);
        send_beat(1'b0, 32'h80123456, 8'd0, 24'd0);

        configure(dpr_pkg::FMT_1BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd13, 9'd1);
        send_beat(1'b0, 32'hFFFFFFFF, 8'd0, 24'd0);
        send_beat(1'b0, 32'h0000A55A, 8'd0, 24'd0);
        run_words(6);

        configure(dpr_pkg::FMT_4BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd7, 9'd12);
        send_beat(1'b0, 32'hF00F7887, 8'd0, 24'd0);
        run_words(6);

        configure(dpr_pkg::FMT_8BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd5, 9'd0);
        send_beat(1'b0, 32'hFF00807F, 8'd0, 24'd0);
        run_words(4);

        configure(dpr_pkg::FMT_8BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd6, 9'd16);
        send_beat(1'b0, 32'h0F00070E, 8'd0, 24'd0);
        run_words(6);

        configure(dpr_pkg::FMT_24BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd5, 9'd256);
        run_words(12);

        configure(dpr_pkg::FMT_32BPP, 1'b1, 32'hFFFFFFFF, 32'h80000000, 32'h00000001,
                  32'hF0000000, 13'd3, 9'd256);
        send_beat(1'b0, 32'hFFFFFFFF, 8'd0, 24'd0);
        send_beat(1'b0, 32'h00000000, 8'd0, 24'd0);
        run_words(4);

        configure(dpr_pkg::FMT_32BPP, 1'b1, 32'h00007C00, 32'h000003E0, 32'h0000001F,
                  32'h0, 13'd4, 9'd256);
        run_words(6);

        configure(dpr_pkg::FMT_32BPP, 1'b1, 32'h0, $urandom(), $urandom(), $urandom(),
                  13'd2, 9'd100);
        run_words(6);

        configure(3'd7, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd0, 9'd256);
        run_words(6);

        configure(dpr_pkg::FMT_1BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'h1FFF, 9'h1FF);
        run_words(12);

        configure(dpr_pkg::FMT_8BPP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 13'd4096, 9'd9);
        run_words(6);

        for (int ph = 0; ph < 4; ph++)
        begin
            configure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom(),
                      $urandom(), $urandom(),
                      ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom(),
                      13'($urandom_range(0, 40)), 9'($urandom_range(0, 16)));
            if (ph == 3)
                quiet = 1;
            run_words(8);
        end

        drain();
        if (sb.errors == 0 && sb.px_q.size() == 0)
            $display("PASS dib_pixel_to_rgba_converter");
        else
            $display("FAIL dib_pixel_to_rgba_converter");
        $finish;
    end
endmodule
